### rtl/tkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_pkg
// shared types, widths and helpers of the top-k seed tracker
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int LIST_DEPTH = 10;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int SEED_W  = 31;
  localparam int KEY_W   = 63;
  localparam int SLOT_W  = 4;
  localparam int RANK_W  = 4;
  localparam int FILL_W  = 5;

  localparam int IN_FIELDS_W = SEED_W + KEY_W + SLOT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORDER_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BEST_INIT  = 1'b1;

  localparam logic [KEY_W-1:0] BEST_INIT_RESET = {KEY_W{1'b1}};

  // input action codes
  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // result beat, first field in the highest bits
  typedef struct packed {
    logic [KEY_W-1:0]  best_value;
    logic [KEY_W-1:0]  entry_key;
    logic [SEED_W-1:0] entry_seed;
    logic              entry_valid;
    logic [FILL_W-1:0] fill_count;
    logic [RANK_W-1:0] rank;
    logic              accepted;
  } out_beat_t;

  localparam int OUT_DATA_W = $bits(out_beat_t);

  // mode 0: smaller is better, mode 1: larger is better
  function automatic logic is_better(input logic [KEY_W-1:0] a,
                                     input logic [KEY_W-1:0] b,
                                     input logic             mode);
    is_better = mode ? (a > b) : (a < b);
  endfunction

endpackage

### rtl/top_k_seed_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_seed_tracker_core
// keeps the best (seed, key) pairs sorted in a small ram and tracks a best key
// ----------------------------------------------------------------------------
// offer: one ram pass over the filled entries, then a tail step; when the
//   list is full a check against the last entry comes first (rejects stop there)
// read: one ram read, skipped when the slot is beyond the fill
// one item in flight; the next beat is taken once the result is registered
// reset empties the list, sets mode 0 and the running best to the max key
// ----------------------------------------------------------------------------
module top_k_seed_tracker_core import tkst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_W-1:0]     s_axis_tdata,  // seed, key, slot, zero pad
  input  logic                     s_axis_tuser,  // action
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_W-1:0]    m_axis_tdata,  // accepted, rank, fill_count,
                                                  // entry_valid, entry_seed,
                                                  // entry_key, best_value
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [KEY_W-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_TAIL,
    ST_RD,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               found_q, found_d;
  entry_t             carry_q, carry_d;
  entry_t             item_q, item_d;
  logic               mode_q, mode_d;
  logic [KEY_W-1:0]   best_q, best_d;
  out_beat_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;

  entry_t             mem_q [LIST_DEPTH];
  entry_t             rd_data_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  logic               s_fire;
  logic               full;
  logic               last_idx;
  logic [SLOT_W-1:0]  in_slot;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CNT_W'(LIST_DEPTH));
  assign last_idx      = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign in_slot       = s_axis_tdata[SEED_W+KEY_W +: SLOT_W];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    found_d     = found_q;
    carry_d     = carry_q;
    item_d      = item_q;
    mode_d      = mode_q;
    best_d      = best_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = item_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          item_d.seed = s_axis_tdata[SEED_W-1:0];
          item_d.key  = s_axis_tdata[SEED_W +: KEY_W];
          found_d     = 1'b0;
          idx_d       = '0;
          res_d       = '0;
          if (s_axis_tuser == ACT_READ) begin
            res_d.rank = in_slot;
            if (FILL_W'(in_slot) < FILL_W'(cnt_q)) begin
              rd_en   = 1'b1;
              rd_addr = in_slot[IDX_W-1:0];
              state_d = ST_RD;
            end else begin
              state_d = ST_DONE;
            end
          end else if (cnt_q == '0) begin
            state_d = ST_TAIL;
          end else if (full) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(LIST_DEPTH - 1);
            state_d = ST_CHECK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_CHECK: begin
        if (is_better(item_q.key, rd_data_q.key, mode_q)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!found_q) begin
          if (is_better(item_q.key, rd_data_q.key, mode_q)) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = item_q;
            carry_d   = rd_data_q;
            found_d   = 1'b1;
            pos_d     = idx_q;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = carry_q;
          carry_d   = rd_data_q;
        end
        if (last_idx) begin
          state_d = ST_TAIL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IDX_W'(1);
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      ST_TAIL: begin
        if (!found_q) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IDX_W-1:0];
          mem_wdata = item_q;
          res_d.rank = RANK_W'(cnt_q);
        end else begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[IDX_W-1:0];
            mem_wdata = carry_q;
          end
          res_d.rank = RANK_W'(pos_q);
        end
        if (!full) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (is_better(item_q.key, best_q, mode_q)) begin
          best_d = item_q.key;
        end
        res_d.accepted = 1'b1;
        state_d        = ST_DONE;
      end
      ST_RD: begin
        res_d.entry_valid = 1'b1;
        res_d.entry_seed  = rd_data_q.seed;
        res_d.entry_key   = rd_data_q.key;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d      = 1'b1;
          out_d            = res_q;
          out_d.fill_count = FILL_W'(cnt_q);
          out_d.best_value = best_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORDER_MODE: mode_d = cfg_data_i[0];
        REG_BEST_INIT:  best_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      mode_q      <= 1'b0;
      best_q      <= BEST_INIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      mode_q      <= mode_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    item_q  <= item_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // list ram, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LIST_DEPTH))
    else $error("fill count above list depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CNT_W'(mem_waddr) < CNT_W'(LIST_DEPTH)))
    else $error("ram write beyond list depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("ram read and write collide on one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= $past(cnt_q))
    else $error("fill count went down");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) |=> (state_q == ST_DONE && res_q.accepted && cnt_q != '0))
    else $error("accepted offer left list empty");

endmodule
